>>> rtl/mac_grid_velocity_sampler_unit_defines.svh
// Assertion macros shared by the velocity sampler RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef MAC_GRID_VELOCITY_SAMPLER_UNIT_DEFINES_SVH
`define MAC_GRID_VELOCITY_SAMPLER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// clocked check, idle while reset is high
`define MGVS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// clocked check that also holds through reset
`define MGVS_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MGVS_ASSERT(lbl, clk, rst, prop, msg)
`define MGVS_ASSERT_NR(lbl, clk, prop, msg)
`endif

`endif

>>> rtl/mgvs_pkg.sv
// Types and codes of the velocity sampler: beat payloads, commands, CSR map.
// No dependencies.
package mgvs_pkg;

   localparam int IDX_W      = 13;
   localparam int CSR_ADDR_W = 4;

   typedef enum logic [1:0] {
      CMD_WRITE_H = 2'd0,
      CMD_WRITE_V = 2'd1,
      CMD_SAMPLE  = 2'd2
   } command_type;

   localparam logic [1:0] REG_INV_CELL_SIZE = 2'd0;
   localparam logic [1:0] REG_CELLS_X       = 2'd1;
   localparam logic [1:0] REG_CELLS_Y       = 2'd2;

   typedef struct packed {
      logic [1:0]        command;
      logic [IDX_W-1:0]  entry_index;
      logic signed [31:0] entry_value;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
   } req_type;

   typedef struct packed {
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
   } rsp_type;

endpackage

>>> rtl/mac_grid_velocity_sampler_unit.sv
// Velocity sampler on a staggered grid: stores, CSRs and the sample pipeline.
// Depends on mgvs_pkg, mgvs_ram and mac_grid_velocity_sampler_unit_defines.svh.
//
// Takes one beat per cycle unless the result stalls, writes and samples mixed
// freely. Writes land in the stores at the stage where samples read them, so
// every sample sees all earlier writes. Each velocity store is held in four
// copies, one per bilinear tap, so all eight taps are read together. The
// stores are not cleared: sample only where entries were written. A stalled
// result stalls the whole pipeline.
`include "mac_grid_velocity_sampler_unit_defines.svh"
module mac_grid_velocity_sampler_unit #(
   parameter int MAX_CELLS_X = 64,
   parameter int MAX_CELLS_Y = 64,
   parameter int FRAC_BITS   = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  mgvs_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output mgvs_pkg::rsp_type                 rsp_data,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [mgvs_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);

   localparam int XW = $clog2(MAX_CELLS_X + 2);
   localparam int YW = $clog2(MAX_CELLS_Y + 2);
   localparam int HDEPTH = (MAX_CELLS_X + 1) * MAX_CELLS_Y;
   localparam int VDEPTH = MAX_CELLS_X * (MAX_CELLS_Y + 1);
   localparam int HAW = $clog2(HDEPTH);
   localparam int VAW = $clog2(VDEPTH);
   localparam int PW  = 57;
   localparam int GW  = PW - FRAC_BITS + 1;
   localparam int CIW = GW - FRAC_BITS;
   localparam int WW  = FRAC_BITS + 1;
   localparam int TPW = WW + 33;
   localparam int SW  = TPW + 2;
   localparam int QW  = SW - FRAC_BITS;
   localparam logic [WW-1:0] ONE = WW'(1) << FRAC_BITS;
   localparam logic signed [GW-1:0] HALF = GW'(1) << (FRAC_BITS - 1);
   localparam logic signed [SW-1:0] RND = SW'(1) << (FRAC_BITS - 1);
   localparam logic signed [QW-1:0] SAT_MAX = QW'(64'sd2147483647);
   localparam logic signed [QW-1:0] SAT_MIN = QW'(-64'sd2147483648);

   // CSRs
   logic [23:0] inv_ff;
   logic [6:0]  cx_ff, cy_ff;
   logic        csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_ff <= 24'd65536;
         cx_ff  <= 7'd64;
         cy_ff  <= 7'd64;
      end else if (csr_wr) begin
         case (csr_paddr[3:2])
            mgvs_pkg::REG_INV_CELL_SIZE: inv_ff <= csr_pwdata[23:0];
            mgvs_pkg::REG_CELLS_X:       cx_ff  <= csr_pwdata[6:0];
            mgvs_pkg::REG_CELLS_Y:       cy_ff  <= csr_pwdata[6:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         mgvs_pkg::REG_INV_CELL_SIZE: csr_prdata = {8'd0, inv_ff};
         mgvs_pkg::REG_CELLS_X:       csr_prdata = {25'd0, cx_ff};
         mgvs_pkg::REG_CELLS_Y:       csr_prdata = {25'd0, cy_ff};
         default:                     csr_prdata = 32'd0;
      endcase
   end

   // clamped grid size
   logic [XW-1:0] nx, hdim_i;
   logic [YW-1:0] ny, vdim_j;
   logic [31:0]   hsize, vsize;

   always_comb begin
      if (cx_ff == 7'd0) begin
         nx = XW'(1);
      end else if (32'(cx_ff) > MAX_CELLS_X) begin
         nx = XW'(MAX_CELLS_X);
      end else begin
         nx = XW'(cx_ff);
      end
      if (cy_ff == 7'd0) begin
         ny = YW'(1);
      end else if (32'(cy_ff) > MAX_CELLS_Y) begin
         ny = YW'(MAX_CELLS_Y);
      end else begin
         ny = YW'(cy_ff);
      end
      hdim_i = nx + XW'(1);
      vdim_j = ny + YW'(1);
      hsize  = 32'(hdim_i) * 32'(ny);
      vsize  = 32'(nx) * 32'(vdim_j);
   end

   // flow control
   logic adv, accept, rsp_valid_ff;
   mgvs_pkg::rsp_type rsp_data_ff;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;
   assign accept    = req_valid && !req_stall;

   // stage 1: input beat
   logic s1_valid_ff, s1_wrh_ff, s1_wrv_ff, s1_smp_ff;
   mgvs_pkg::req_type s1_req_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_req_ff <= req_data;
         s1_wrh_ff <= accept && (req_data.command == mgvs_pkg::CMD_WRITE_H)
                      && (32'(req_data.entry_index) < hsize);
         s1_wrv_ff <= accept && (req_data.command == mgvs_pkg::CMD_WRITE_V)
                      && (32'(req_data.entry_index) < vsize);
         s1_smp_ff <= req_data.command == mgvs_pkg::CMD_SAMPLE;
      end
   end

   // stage 2: position times reciprocal cell size
   logic s2_valid_ff, s2_wrh_ff, s2_wrv_ff, s2_smp_ff;
   logic [mgvs_pkg::IDX_W-1:0] s2_idx_ff;
   logic [31:0] s2_val_ff;
   logic signed [PW-1:0] s2_px_ff, s2_py_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_wrh_ff <= s1_wrh_ff;
         s2_wrv_ff <= s1_wrv_ff;
         s2_smp_ff <= s1_smp_ff;
         s2_idx_ff <= s1_req_ff.entry_index;
         s2_val_ff <= s1_req_ff.entry_value;
         s2_px_ff  <= PW'(s1_req_ff.pos_x) * PW'($signed({1'b0, inv_ff}));
         s2_py_ff  <= PW'(s1_req_ff.pos_y) * PW'($signed({1'b0, inv_ff}));
      end
   end

   // stage 3: grid coordinates, cell indices, weights, tap range
   logic signed [GW-1:0]  gx0, gy0, gxh, gyh;
   logic signed [GW-1:0]  gx_in [2];
   logic signed [GW-1:0]  gy_in [2];
   logic signed [CIW-1:0] ci_in [2];
   logic signed [CIW-1:0] cj_in [2];
   logic [XW-1:0]         dimi [2];
   logic [YW-1:0]         dimj [2];
   logic [3:0]            tv_in [2];
   logic signed [31:0]    ii32, jj32;

   always_comb begin
      gx0 = GW'(s2_px_ff >>> FRAC_BITS);
      gy0 = GW'(s2_py_ff >>> FRAC_BITS);
      gxh = gx0 - HALF;
      gyh = gy0 - HALF;
      gx_in[0] = gx0;
      gy_in[0] = gyh;
      gx_in[1] = gxh;
      gy_in[1] = gy0;
      dimi[0] = hdim_i;
      dimj[0] = ny;
      dimi[1] = nx;
      dimj[1] = vdim_j;
      ii32 = '0;
      jj32 = '0;
      for (int s = 0; s < 2; s++) begin
         ci_in[s] = CIW'(gx_in[s] >>> FRAC_BITS);
         cj_in[s] = CIW'(gy_in[s] >>> FRAC_BITS);
         for (int t = 0; t < 4; t++) begin
            ii32 = 32'(ci_in[s]) + 32'(t % 2);
            jj32 = 32'(cj_in[s]) + 32'(t / 2);
            tv_in[s][t] = (ii32 >= 0) && (ii32 < $signed(32'(dimi[s])))
                          && (jj32 >= 0) && (jj32 < $signed(32'(dimj[s])));
         end
      end
   end

   logic s3_valid_ff, s3_wrh_ff, s3_wrv_ff, s3_smp_ff;
   logic [mgvs_pkg::IDX_W-1:0] s3_idx_ff;
   logic [31:0]          s3_val_ff;
   logic [XW-1:0]        s3_ci_ff [2];
   logic [YW-1:0]        s3_cj_ff [2];
   logic [FRAC_BITS-1:0] s3_wx_ff [2];
   logic [FRAC_BITS-1:0] s3_wy_ff [2];
   logic [3:0]           s3_tv_ff [2];

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_wrh_ff <= s2_wrh_ff;
         s3_wrv_ff <= s2_wrv_ff;
         s3_smp_ff <= s2_smp_ff;
         s3_idx_ff <= s2_idx_ff;
         s3_val_ff <= s2_val_ff;
         for (int s = 0; s < 2; s++) begin
            s3_ci_ff[s] <= XW'(ci_in[s]);
            s3_cj_ff[s] <= YW'(cj_in[s]);
            s3_wx_ff[s] <= gx_in[s][FRAC_BITS-1:0];
            s3_wy_ff[s] <= gy_in[s][FRAC_BITS-1:0];
            s3_tv_ff[s] <= tv_in[s];
         end
      end
   end

   // tap addresses and tap weights; store writes land here too
   logic [HAW-1:0]    haddr [4];
   logic [VAW-1:0]    vaddr [4];
   logic [WW-1:0]     w_in [2][4];
   logic [XW-1:0]     ii [2];
   logic [YW-1:0]     jj [2];
   logic [WW-1:0]     wa, wb;
   logic [2*WW-1:0]   wp;

   always_comb begin
      wa = '0;
      wb = '0;
      wp = '0;
      for (int t = 0; t < 4; t++) begin
         for (int s = 0; s < 2; s++) begin
            ii[s] = s3_ci_ff[s] + XW'(t % 2);
            jj[s] = s3_cj_ff[s] + YW'(t / 2);
            wa = (t % 2 == 1) ? {1'b0, s3_wx_ff[s]} : ONE - {1'b0, s3_wx_ff[s]};
            wb = (t / 2 == 1) ? {1'b0, s3_wy_ff[s]} : ONE - {1'b0, s3_wy_ff[s]};
            wp = (2*WW)'(wa) * (2*WW)'(wb);
            w_in[s][t] = wp[2*FRAC_BITS -: WW];
         end
         haddr[t] = HAW'(ii[0]) + HAW'(hdim_i) * HAW'(jj[0]);
         vaddr[t] = VAW'(ii[1]) + VAW'(nx) * VAW'(jj[1]);
      end
   end

   logic [31:0] hq [4];
   logic [31:0] vq [4];

   for (genvar t = 0; t < 4; t++) begin : g_tap
      mgvs_ram #(.W(32), .DEPTH(HDEPTH)) u_hram (
         .clock   (clock),
         .wr_en   (adv && s3_valid_ff && s3_wrh_ff),
         .wr_addr (HAW'(s3_idx_ff)),
         .wr_data (s3_val_ff),
         .rd_en   (adv),
         .rd_addr (haddr[t]),
         .rd_data (hq[t])
      );
      mgvs_ram #(.W(32), .DEPTH(VDEPTH)) u_vram (
         .clock   (clock),
         .wr_en   (adv && s3_valid_ff && s3_wrv_ff),
         .wr_addr (VAW'(s3_idx_ff)),
         .wr_data (s3_val_ff),
         .rd_en   (adv),
         .rd_addr (vaddr[t]),
         .rd_data (vq[t])
      );
   end

   // stage 4: weights beside store data
   logic s4_valid_ff, s4_smp_ff;
   logic [WW-1:0] s4_w_ff [2][4];
   logic [3:0]    s4_tv_ff [2];

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (adv) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_smp_ff <= s3_smp_ff;
         s4_w_ff   <= w_in;
         s4_tv_ff  <= s3_tv_ff;
      end
   end

   // stage 5: weighted taps
   logic s5_valid_ff, s5_smp_ff;
   logic signed [TPW-1:0] s5_pr_ff [2][4];
   logic signed [TPW-1:0] pr_in [2][4];

   always_comb begin
      for (int t = 0; t < 4; t++) begin
         pr_in[0][t] = s4_tv_ff[0][t] ?
            TPW'($signed({1'b0, s4_w_ff[0][t]})) * TPW'($signed(hq[t])) : '0;
         pr_in[1][t] = s4_tv_ff[1][t] ?
            TPW'($signed({1'b0, s4_w_ff[1][t]})) * TPW'($signed(vq[t])) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (adv) begin
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s5_smp_ff <= s4_smp_ff;
         s5_pr_ff  <= pr_in;
      end
   end

   // output: sum, round, saturate
   logic signed [SW-1:0] sum_in [2];
   logic signed [QW-1:0] q_in [2];
   logic signed [31:0]   vel_in [2];

   always_comb begin
      for (int s = 0; s < 2; s++) begin
         sum_in[s] = SW'(s5_pr_ff[s][0]) + SW'(s5_pr_ff[s][1])
                   + SW'(s5_pr_ff[s][2]) + SW'(s5_pr_ff[s][3]) + RND;
         q_in[s] = QW'(sum_in[s] >>> FRAC_BITS);
         if (q_in[s] > SAT_MAX) begin
            vel_in[s] = 32'sh7fffffff;
         end else if (q_in[s] < SAT_MIN) begin
            vel_in[s] = 32'sh80000000;
         end else begin
            vel_in[s] = 32'(q_in[s]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= s5_valid_ff && s5_smp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff.vel_x <= vel_in[0];
         rsp_data_ff.vel_y <= vel_in[1];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `MGVS_ASSERT(a_sample_reaches_output, clock, reset, (adv && s5_valid_ff && s5_smp_ff) |=> rsp_valid_ff, "sample beat lost before output")
   `MGVS_ASSERT(a_range_write_dropped, clock, reset, (accept && (req_data.command == mgvs_pkg::CMD_WRITE_H) && (32'(req_data.entry_index) >= hsize)) |=> !s1_wrh_ff, "out of range write kept")
   `MGVS_ASSERT(a_masked_tap_zero, clock, reset, (adv && s4_valid_ff && !s4_tv_ff[0][0]) |=> (s5_pr_ff[0][0] == '0), "off-grid tap contributes")
   `MGVS_ASSERT_NR(a_reset_clears_output, clock, reset |=> !rsp_valid_ff, "result valid after reset")

endmodule

>>> rtl/mgvs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mgvs_ram #(
   parameter int W = 32,
   parameter int DEPTH = 64,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [W-1:0]  wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [W-1:0]  rd_data
);

   logic [W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
